### hw/rtl/mtac_pkg.sv
`timescale 1ns / 1ps
package mtac_pkg;

	localparam int ADDR_W      = 48;
	localparam int TIME_W      = 32;
	localparam int CFG_W       = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CLASS_W     = 6;
	localparam int ENTRIES_DEF = 32;

	localparam logic [CFG_W-1:0] TIMEOUT_RST = 8'd5;
	localparam logic [CFG_W-1:0] PERIOD_RST  = 8'd5;

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 2'd1;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic ACT_ALLOW    = 1'b0;
	localparam logic ACT_DISALLOW = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_SCAN,
		ST_SW_RD,
		ST_SW_CHK,
		ST_SW_MOV
	} state_t;

	typedef struct packed {
		logic load_add;
		logic tick;
		logic scan_rd;
		logic refresh;
		logic append;
		logic sw_next;
		logic sw_kill;
		logic sw_move;
		logic sw_end;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic more;
		logic full;
		logic stale;
		logic sweep_due;
	} sts_t;

endpackage

### hw/rtl/mac_table_with_aging_and_class_slots.sv
`timescale 1ns / 1ps
// Learning table of up to ENTRIES 48-bit addresses with per-entry age and class slot. A request
// is taken when start is high while busy is low. An add scans the table one entry per cycle
// through the read port of the entry RAM: busy stays high until the address is found or every
// entry has been read. A newly learned address gives one allow result in the cycle in which busy
// falls. A tick that does not start a sweep is absorbed in its own cycle and busy stays low. A
// sweep reads and checks each entry in turn; an expired entry is freed and the last entry is
// moved into its hole, and its disallow result is given out at the next expiry or at the end
// of the sweep. Results appear on result_strobe for exactly one cycle and cannot be held off, so
// the receiver must take every strobe. The configuration channel always accepts and must only be
// written while busy is low.
module mac_table_with_aging_and_class_slots #(
	parameter int ENTRIES = mtac_pkg::ENTRIES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               op,
	input  logic [mtac_pkg::ADDR_W-1:0]        mac,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mtac_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mtac_pkg::CFG_W-1:0]         cfg_data,
	output logic                               result_strobe,
	output logic                               action,
	output logic [mtac_pkg::ADDR_W-1:0]        addr_out,
	output logic [mtac_pkg::CLASS_W-1:0]       class_id,
	output logic                               last
);

	mtac_pkg::cmd_t cmd;
	mtac_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	mtac_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	mtac_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.mac           (mac),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.sts           (sts),
		.result_strobe (result_strobe),
		.action        (action),
		.addr_out      (addr_out),
		.class_id      (class_id),
		.last          (last)
	);

endmodule

### hw/rtl/mtac_ram.sv
`timescale 1ns / 1ps
module mtac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/mtac_ctrl.sv
`timescale 1ns / 1ps
module mtac_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            op,
	input  mtac_pkg::sts_t  sts,
	output mtac_pkg::cmd_t  cmd,
	output logic            busy
);

	mtac_pkg::state_t state_q;
	mtac_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtac_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			mtac_pkg::ST_IDLE: begin
				if (start) begin
					if (op == mtac_pkg::OP_ADD) begin
						cmd.load_add = 1'b1;
						state_d      = mtac_pkg::ST_ADD_SCAN;
					end else begin
						cmd.tick = 1'b1;
						if (sts.sweep_due) begin
							state_d = mtac_pkg::ST_SW_RD;
						end
					end
				end
			end
			mtac_pkg::ST_ADD_SCAN: begin
				if (sts.hit) begin
					cmd.refresh = 1'b1;
					state_d     = mtac_pkg::ST_IDLE;
				end else if (sts.more) begin
					cmd.scan_rd = 1'b1;
				end else begin
					cmd.append = !sts.full;
					state_d    = mtac_pkg::ST_IDLE;
				end
			end
			mtac_pkg::ST_SW_RD: begin
				if (sts.more) begin
					state_d = mtac_pkg::ST_SW_CHK;
				end else begin
					cmd.sw_end = 1'b1;
					state_d    = mtac_pkg::ST_IDLE;
				end
			end
			mtac_pkg::ST_SW_CHK: begin
				if (sts.stale) begin
					cmd.sw_kill = 1'b1;
					state_d     = mtac_pkg::ST_SW_MOV;
				end else begin
					cmd.sw_next = 1'b1;
					state_d     = mtac_pkg::ST_SW_RD;
				end
			end
			mtac_pkg::ST_SW_MOV: begin
				cmd.sw_move = 1'b1;
				state_d     = mtac_pkg::ST_SW_RD;
			end
			default: begin
				state_d = mtac_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != mtac_pkg::ST_IDLE);

endmodule

### hw/rtl/mtac_dp.sv
`timescale 1ns / 1ps
module mtac_dp #(
	parameter int ENTRIES = mtac_pkg::ENTRIES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [mtac_pkg::ADDR_W-1:0]          mac,
	input  logic                                 cfg_we,
	input  logic [mtac_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mtac_pkg::CFG_W-1:0]           cfg_data,
	input  mtac_pkg::cmd_t                       cmd,
	output mtac_pkg::sts_t                       sts,
	output logic                                 result_strobe,
	output logic                                 action,
	output logic [mtac_pkg::ADDR_W-1:0]          addr_out,
	output logic [mtac_pkg::CLASS_W-1:0]         class_id,
	output logic                                 last
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int AW = mtac_pkg::ADDR_W;
	localparam int TW = mtac_pkg::TIME_W;
	localparam int EW = AW + TW + IW;

	logic [mtac_pkg::CFG_W-1:0] timeout_q;
	logic [mtac_pkg::CFG_W-1:0] period_q;
	logic [mtac_pkg::CFG_W-1:0] countdown_q;
	logic [TW-1:0]              now_q;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              idx_q;
	logic [CW-1:0]              cnt_dec;
	logic [IW-1:0]              cmp_idx_q;
	logic                       cmp_vld_q;
	logic [ENTRIES-1:0]         slot_used_q;
	logic                       free_found_q;
	logic [IW-1:0]              free_slot_q;
	logic [AW-1:0]              mac_q;
	logic                       pend_vld_q;
	logic [AW-1:0]              pend_addr_q;
	logic [IW-1:0]              pend_slot_q;

	logic                       strobe_q;
	logic                       action_q;
	logic [AW-1:0]              addr_q;
	logic [mtac_pkg::CLASS_W-1:0] class_q;
	logic                       last_q;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic [IW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;

	logic [AW-1:0] rd_mac;
	logic [TW-1:0] rd_time;
	logic [IW-1:0] rd_slot;
	logic [TW-1:0] age;
	logic [IW-1:0] new_slot;

	logic          emit;
	logic          e_action;
	logic [AW-1:0] e_addr;
	logic [IW-1:0] e_slot;
	logic          e_last;
	logic [IW:0]   e_slot_inc;

	mtac_ram #(
		.WIDTH (EW),
		.DEPTH (ENTRIES),
		.AW    (IW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_mac  = ram_rdata[EW-1 -: AW];
	assign rd_time = ram_rdata[IW +: TW];
	assign rd_slot = ram_rdata[IW-1:0];
	assign age     = now_q - rd_time;
	assign cnt_dec = count_q - CW'(1);
	assign new_slot = free_found_q ? free_slot_q : count_q[IW-1:0];

	assign sts.hit       = cmp_vld_q && (rd_mac == mac_q);
	assign sts.more      = (idx_q < count_q);
	assign sts.full      = (count_q == CW'(ENTRIES));
	assign sts.stale     = (age > TW'(timeout_q));
	assign sts.sweep_due = (countdown_q == '0);

	always_comb begin
		ram_raddr = idx_q[IW-1:0];
		if (cmd.sw_kill) begin
			ram_raddr = cnt_dec[IW-1:0];
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[IW-1:0];
		ram_wdata = ram_rdata;
		if (cmd.refresh) begin
			ram_we    = 1'b1;
			ram_waddr = cmp_idx_q;
			ram_wdata = {rd_mac, now_q, rd_slot};
		end else if (cmd.append) begin
			ram_we    = 1'b1;
			ram_waddr = count_q[IW-1:0];
			ram_wdata = {mac_q, now_q, new_slot};
		end else if (cmd.sw_move) begin
			ram_we = 1'b1;
		end
	end

	always_comb begin
		emit     = 1'b0;
		e_action = mtac_pkg::ACT_DISALLOW;
		e_addr   = pend_addr_q;
		e_slot   = pend_slot_q;
		e_last   = 1'b0;
		if (cmd.append) begin
			emit     = 1'b1;
			e_action = mtac_pkg::ACT_ALLOW;
			e_addr   = mac_q;
			e_slot   = new_slot;
			e_last   = 1'b1;
		end else if (cmd.sw_kill) begin
			emit = pend_vld_q;
		end else if (cmd.sw_end) begin
			emit   = pend_vld_q;
			e_last = 1'b1;
		end
	end

	assign e_slot_inc = (IW + 1)'(e_slot) + (IW + 1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= mtac_pkg::TIMEOUT_RST;
			period_q  <= mtac_pkg::PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mtac_pkg::REG_TIMEOUT: timeout_q <= cfg_data;
				mtac_pkg::REG_PERIOD:  period_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// seconds counter and sweep countdown
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			countdown_q <= '0;
		end else if (cmd.tick) begin
			now_q <= now_q + TW'(1);
			if (countdown_q == '0) begin
				countdown_q <= (period_q == '0) ? '0 : period_q - 8'd1;
			end else begin
				countdown_q <= countdown_q - 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			idx_q        <= '0;
			cmp_vld_q    <= 1'b0;
			slot_used_q  <= '0;
			free_found_q <= 1'b0;
			pend_vld_q   <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			cmp_vld_q <= cmd.scan_rd;
			strobe_q  <= emit;
			if (cmd.load_add || (cmd.tick && sts.sweep_due)) begin
				idx_q        <= '0;
				free_found_q <= 1'b0;
				pend_vld_q   <= 1'b0;
			end
			if (cmd.scan_rd) begin
				idx_q <= idx_q + CW'(1);
				if (!free_found_q && !slot_used_q[idx_q[IW-1:0]]) begin
					free_found_q <= 1'b1;
				end
			end
			if (cmd.sw_next) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.append) begin
				count_q               <= count_q + CW'(1);
				slot_used_q[new_slot] <= 1'b1;
			end
			if (cmd.sw_kill) begin
				count_q              <= cnt_dec;
				slot_used_q[rd_slot] <= 1'b0;
				pend_vld_q           <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_add) begin
			mac_q <= mac;
		end
		if (cmd.scan_rd) begin
			cmp_idx_q <= idx_q[IW-1:0];
			if (!free_found_q) begin
				free_slot_q <= idx_q[IW-1:0];
			end
		end
		if (cmd.sw_kill) begin
			pend_addr_q <= rd_mac;
			pend_slot_q <= rd_slot;
		end
		if (emit) begin
			action_q <= e_action;
			addr_q   <= e_addr;
			class_q  <= mtac_pkg::CLASS_W'(e_slot_inc);
			last_q   <= e_last;
		end
	end

	assign result_strobe = strobe_q;
	assign action        = action_q;
	assign addr_out      = addr_q;
	assign class_id      = class_q;
	assign last          = last_q;

endmodule
